// ----- design/ghf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ghf_pkg
// Shared constants, codes and types of the ground height histogram filter.
// ----------------------------------------------------------------------------
package ghf_pkg;

  localparam int GRID_CELLS_DEF   = 8;
  localparam int HEIGHT_BINS_DEF  = 30;
  localparam int CELL_SIZE_MM_DEF = 5000;
  localparam int COUNT_WIDTH_DEF  = 16;

  localparam int BIN_MM     = 100;
  localparam int CRD_W      = 24;   // covers +-(GRID_CELLS/2)*CELL_SIZE_MM at the largest grid
  localparam int STEP_CNT_W = 6;    // up to 63 thresholds per index search
  localparam int GND_W      = 13;
  localparam int OFS_W      = 11;

  localparam logic signed [GND_W-1:0] GROUND_RESET_MM = 13'sd120;

  localparam logic [1:0] FUNC_LOAD     = 2'd0;
  localparam logic [1:0] FUNC_COMPUTE  = 2'd1;
  localparam logic [1:0] FUNC_CLASSIFY = 2'd2;

  // request to the shared threshold-count unit
  typedef struct packed {
    logic                          go;
    logic signed [CRD_W-1:0]       value;
    logic signed [CRD_W-1:0]       start;
    logic signed [CRD_W-1:0]       step;
    logic        [STEP_CNT_W-1:0]  nsteps;
  } ghf_step_req_t;

  typedef struct packed {
    logic                          done;
    logic        [STEP_CNT_W-1:0]  count;
  } ghf_step_rsp_t;

endpackage
`default_nettype wire

// ----- design/ghf_step_count.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ghf_step_count
// Shared compare unit: counts how many of nsteps evenly spaced thresholds
// (start, start+step, ...) lie at or below a value, one threshold a cycle.
// ----------------------------------------------------------------------------
module ghf_step_count (
  input  logic                   clk,
  input  logic                   rst,
  input  ghf_pkg::ghf_step_req_t req,
  output ghf_pkg::ghf_step_rsp_t rsp
);
  import ghf_pkg::*;

  logic                         running;
  logic [STEP_CNT_W-1:0]        left;
  logic [STEP_CNT_W-1:0]        cnt;
  logic signed [CRD_W-1:0]      value;
  logic signed [CRD_W-1:0]      thr;
  logic signed [CRD_W-1:0]      step;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
    end else if (req.go) begin
      running <= 1'b1;
    end else if (running && left == '0) begin
      running <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      value <= req.value;
      thr   <= req.start;
      step  <= req.step;
      left  <= req.nsteps;
      cnt   <= '0;
    end else if (running && left != '0) begin
      if (value >= thr) begin
        cnt <= cnt + 1'b1;
      end
      thr  <= thr + step;
      left <= left - 1'b1;
    end
  end

  assign rsp.done  = running && (left == '0);
  assign rsp.count = cnt;

endmodule
`default_nettype wire

// ----- design/ghf_hist_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ghf_hist_ram
// Histogram count store: one write port, one registered read port.
// A read and a write at the same address return the old contents.
// ----------------------------------------------------------------------------
module ghf_hist_ram #(
  parameter int DEPTH  = 1920,
  parameter int ADDR_W = 11,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ----- design/ground_height_histogram_filter_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ground_height_histogram_filter_top
// Per-cell ground height estimation from a height histogram, point filter.
// ----------------------------------------------------------------------------
// Usage: a request (func, x_mm, y_mm, z_mm) is taken at a clock edge with
// start high and busy low. Exactly one result per request is shown for one
// cycle with res_valid high; the receiver cannot stall it. ground_offset_mm
// is written through cfg_we/cfg_wdata, by the user only while the block is
// idle; the block itself does not enforce this. Steps per request, with busy
// high from the accept edge and the result shown as busy falls:
//   load in region       three index searches on the shared compare unit,
//                        then read/modify/write
//   classify in region   two index searches, ground read
//   compute              one histogram entry per cycle through the single
//                        memory address, clearing each entry too
//   other requests       busy stays low, result in the next cycle.
// A new request may be taken in the cycle that shows the previous result.
// After reset a clearing pass over all histogram entries (1920 by default) zeroes
// the histogram with busy high; configuration writes are taken meanwhile.
// ----------------------------------------------------------------------------
module ground_height_histogram_filter_top #(
  parameter int GRID_CELLS   = ghf_pkg::GRID_CELLS_DEF,
  parameter int HEIGHT_BINS  = ghf_pkg::HEIGHT_BINS_DEF,
  parameter int CELL_SIZE_MM = ghf_pkg::CELL_SIZE_MM_DEF,
  parameter int COUNT_WIDTH  = ghf_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        func,
  input  logic signed [15:0]                x_mm,
  input  logic signed [15:0]                y_mm,
  input  logic signed [15:0]                z_mm,
  input  logic                              cfg_we,
  input  logic signed [ghf_pkg::OFS_W-1:0]  cfg_wdata,
  output logic                              res_valid,
  output logic                              keep,
  output logic                              in_region,
  output logic signed [ghf_pkg::GND_W-1:0]  cell_ground_mm,
  output logic                              done_res
);
  import ghf_pkg::*;

  localparam int NCELLS     = GRID_CELLS * GRID_CELLS;
  localparam int HIST_DEPTH = NCELLS * HEIGHT_BINS;
  localparam int HA_W       = $clog2(HIST_DEPTH);
  localparam int CELL_W     = $clog2(NCELLS);
  localparam int COL_W      = $clog2(GRID_CELLS);
  localparam int BIN_W      = $clog2(HEIGHT_BINS);
  localparam int HALF_MM    = GRID_CELLS * CELL_SIZE_MM / 2;

  localparam logic signed [CRD_W-1:0] HALF_S      = CRD_W'(HALF_MM);
  localparam logic signed [CRD_W-1:0] NEG_HALF_S  = CRD_W'(-HALF_MM);
  localparam logic signed [CRD_W-1:0] NEG_YMIN_S  = CRD_W'(-(HEIGHT_BINS * BIN_MM));
  localparam logic signed [CRD_W-1:0] COL_START_S =
    CRD_W'((1 - GRID_CELLS / 2) * CELL_SIZE_MM);
  localparam logic signed [CRD_W-1:0] CELL_S      = CRD_W'(CELL_SIZE_MM);
  localparam logic signed [CRD_W-1:0] BIN_S       = CRD_W'(BIN_MM);
  localparam logic signed [GND_W:0]   GND_LO      = (GND_W+1)'(-(2 ** (GND_W - 1)));
  localparam logic signed [GND_W:0]   GND_HI      = (GND_W+1)'(2 ** (GND_W - 1) - 1);

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_XIDX    = 4'd2;
  localparam logic [3:0] S_ZIDX    = 4'd3;
  localparam logic [3:0] S_YIDX    = 4'd4;
  localparam logic [3:0] S_LD_RD   = 4'd5;
  localparam logic [3:0] S_LD_WR   = 4'd6;
  localparam logic [3:0] S_CL_RD   = 4'd7;
  localparam logic [3:0] S_CL_FIN  = 4'd8;
  localparam logic [3:0] S_CMP_RUN = 4'd9;
  localparam logic [3:0] S_CMP_D1  = 4'd10;
  localparam logic [3:0] S_CMP_D2  = 4'd11;

  logic [3:0]               state;
  logic signed [OFS_W-1:0]  offset;
  logic                     computed;

  logic [1:0]               fn;
  logic signed [15:0]       yr;
  logic signed [15:0]       zr;
  logic [COL_W-1:0]         col;
  logic [COL_W-1:0]         row;
  logic [CELL_W-1:0]        cell_idx;

  logic [HA_W-1:0]          haddr;
  logic [CELL_W-1:0]        ccnt;
  logic [BIN_W-1:0]         jcnt;

  logic                     p_valid;
  logic [BIN_W-1:0]         p_j;
  logic [CELL_W-1:0]        p_cell;
  logic [COUNT_WIDTH-1:0]   prev;
  logic [COUNT_WIDTH-1:0]   best;
  logic [COUNT_WIDTH-1:0]   rise;
  logic                     upd;
  logic [BIN_W-1:0]         bin_best;

  logic                     gw_valid;
  logic [CELL_W-1:0]        gw_cell;
  logic [BIN_W-1:0]         gw_bin;
  logic [GND_W-1:0]         bin_mm;
  logic signed [GND_W:0]    gnd_full;
  logic signed [GND_W-1:0]  gnd_sat;

  logic signed [GND_W-1:0]  cell_ground [NCELLS];
  logic signed [GND_W-1:0]  gr_rdata;
  logic signed [GND_W-1:0]  gnd_rd;

  logic                     hist_we;
  logic [COUNT_WIDTH-1:0]   hist_wdata;
  logic [COUNT_WIDTH-1:0]   hist_rd;
  logic [COUNT_WIDTH-1:0]   hist_inc;

  logic signed [CRD_W-1:0]  xs;
  logic signed [CRD_W-1:0]  ys;
  logic signed [CRD_W-1:0]  zs;
  logic signed [CRD_W-1:0]  zrs;
  logic signed [CRD_W-1:0]  neg_yr;
  logic                     ld_in;
  logic                     cl_in;

  ghf_step_req_t            step_req;
  ghf_step_rsp_t            step_rsp;

  assign busy = (state != S_IDLE);

  // region checks on the request ports
  assign xs = {{(CRD_W-16){x_mm[15]}}, x_mm};
  assign ys = {{(CRD_W-16){y_mm[15]}}, y_mm};
  assign zs = {{(CRD_W-16){z_mm[15]}}, z_mm};
  assign ld_in = (ys <= 0) && (ys >= NEG_YMIN_S) &&
                 (xs <= HALF_S) && (xs >= NEG_HALF_S) &&
                 (zs <= HALF_S) && (zs >= NEG_HALF_S);
  assign cl_in = (xs < HALF_S) && (xs > NEG_HALF_S) &&
                 (zs < HALF_S) && (zs > NEG_HALF_S);

  assign zrs    = {{(CRD_W-16){zr[15]}}, zr};
  assign neg_yr = -{{(CRD_W-16){yr[15]}}, yr};

  assign cell_idx = CELL_W'(row) * CELL_W'(GRID_CELLS) + CELL_W'(col);

  // column, row and bin are threshold counts, which also clamps them
  always_comb begin
    step_req        = '0;
    step_req.value  = xs;
    step_req.start  = COL_START_S;
    step_req.step   = CELL_S;
    step_req.nsteps = STEP_CNT_W'(GRID_CELLS - 1);
    if (state == S_IDLE && start) begin
      step_req.go = ((func == FUNC_LOAD) && ld_in) || ((func == FUNC_CLASSIFY) && cl_in);
    end else if (state == S_XIDX && step_rsp.done) begin
      step_req.go    = 1'b1;
      step_req.value = zrs;
    end else if (state == S_ZIDX && step_rsp.done && fn == FUNC_LOAD) begin
      step_req.go     = 1'b1;
      step_req.value  = neg_yr;
      step_req.start  = BIN_S;
      step_req.step   = BIN_S;
      step_req.nsteps = STEP_CNT_W'(HEIGHT_BINS - 1);
    end
  end

  ghf_step_count u_step (
    .clk (clk),
    .rst (rst),
    .req (step_req),
    .rsp (step_rsp)
  );

  // histogram store
  assign hist_inc   = (hist_rd == '1) ? hist_rd : hist_rd + 1'b1;
  assign hist_we    = (state == S_CLEAR) || (state == S_CMP_RUN) || (state == S_LD_WR);
  assign hist_wdata = (state == S_LD_WR) ? hist_inc : '0;

  ghf_hist_ram #(
    .DEPTH  (HIST_DEPTH),
    .ADDR_W (HA_W),
    .DATA_W (COUNT_WIDTH)
  ) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (haddr),
    .wdata (hist_wdata),
    .raddr (haddr),
    .rdata (hist_rd)
  );

  // rise of bin p_j+1 over bin p_j; ties keep the higher bin
  assign rise = prev - hist_rd;
  assign upd  = (prev > hist_rd) && (rise > best);

  assign bin_mm   = GND_W'(gw_bin) * GND_W'(BIN_MM);
  assign gnd_full = {{(GND_W+1-OFS_W){offset[OFS_W-1]}}, offset} - $signed({1'b0, bin_mm});

  always_comb begin
    if (gnd_full < GND_LO) begin
      gnd_sat = GND_LO[GND_W-1:0];
    end else if (gnd_full > GND_HI) begin
      gnd_sat = GND_HI[GND_W-1:0];
    end else begin
      gnd_sat = gnd_full[GND_W-1:0];
    end
  end

  // cell ground store; entries read as the reset value until the first compute
  always_ff @(posedge clk) begin
    gr_rdata <= cell_ground[cell_idx];
    if (gw_valid) begin
      cell_ground[gw_cell] <= gnd_sat;
    end
  end

  assign gnd_rd = computed ? gr_rdata : GROUND_RESET_MM;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      haddr     <= '0;
      offset    <= OFS_W'(GROUND_RESET_MM);
      computed  <= 1'b0;
      res_valid <= 1'b0;
      p_valid   <= 1'b0;
      gw_valid  <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      p_valid   <= (state == S_CMP_RUN);
      gw_valid  <= p_valid && (p_j == '0);
      if (cfg_we) begin
        offset <= cfg_wdata;
      end
      unique case (state)
        S_CLEAR: begin
          if (haddr == HA_W'(HIST_DEPTH - 1)) begin
            state <= S_IDLE;
          end else begin
            haddr <= haddr + 1'b1;
          end
        end
        S_IDLE: begin
          if (start) begin
            priority if (((func == FUNC_LOAD) && ld_in) ||
                         ((func == FUNC_CLASSIFY) && cl_in)) begin
              state <= S_XIDX;
            end else if (func == FUNC_COMPUTE) begin
              state <= S_CMP_RUN;
              haddr <= HA_W'(HEIGHT_BINS - 1);
              ccnt  <= '0;
              jcnt  <= BIN_W'(HEIGHT_BINS - 1);
            end else begin
              res_valid <= 1'b1;
            end
          end
        end
        S_XIDX: begin
          if (step_rsp.done) begin
            state <= S_ZIDX;
          end
        end
        S_ZIDX: begin
          if (step_rsp.done) begin
            state <= (fn == FUNC_LOAD) ? S_YIDX : S_CL_RD;
          end
        end
        S_YIDX: begin
          if (step_rsp.done) begin
            haddr <= HA_W'(cell_idx) * HA_W'(HEIGHT_BINS) + HA_W'(step_rsp.count);
            state <= S_LD_RD;
          end
        end
        S_LD_RD: begin
          state <= S_LD_WR;
        end
        S_LD_WR: begin
          state     <= S_IDLE;
          res_valid <= 1'b1;
        end
        S_CL_RD: begin
          state <= S_CL_FIN;
        end
        S_CL_FIN: begin
          state     <= S_IDLE;
          res_valid <= 1'b1;
        end
        S_CMP_RUN: begin
          // walk each cell from its top bin down, clearing as we go
          if (jcnt == '0) begin
            if (ccnt == CELL_W'(NCELLS - 1)) begin
              state <= S_CMP_D1;
            end else begin
              ccnt  <= ccnt + 1'b1;
              jcnt  <= BIN_W'(HEIGHT_BINS - 1);
              haddr <= haddr + HA_W'(2 * HEIGHT_BINS - 1);
            end
          end else begin
            jcnt  <= jcnt - 1'b1;
            haddr <= haddr - 1'b1;
          end
        end
        S_CMP_D1: begin
          state <= S_CMP_D2;
        end
        S_CMP_D2: begin
          state     <= S_IDLE;
          res_valid <= 1'b1;
          computed  <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    p_j     <= jcnt;
    p_cell  <= ccnt;
    gw_cell <= p_cell;
    gw_bin  <= upd ? BIN_W'(1) : bin_best;

    if (state == S_IDLE && start) begin
      fn             <= func;
      yr             <= y_mm;
      zr             <= z_mm;
      keep           <= 1'b0;
      in_region      <= 1'b0;
      cell_ground_mm <= '0;
      done_res       <= 1'b0;
    end
    if (state == S_XIDX && step_rsp.done) begin
      col <= COL_W'(step_rsp.count);
    end
    if (state == S_ZIDX && step_rsp.done) begin
      row <= COL_W'(step_rsp.count);
    end

    if (p_valid) begin
      prev <= hist_rd;
      if (p_j == BIN_W'(HEIGHT_BINS - 1)) begin
        best     <= '0;
        bin_best <= '0;
      end else if (upd) begin
        best     <= rise;
        bin_best <= p_j + 1'b1;
      end
    end

    if (state == S_LD_WR) begin
      in_region <= 1'b1;
    end
    if (state == S_CL_FIN) begin
      in_region      <= 1'b1;
      cell_ground_mm <= gnd_rd;
      keep           <= (yr > gnd_rd);
    end
    if (state == S_CMP_D2) begin
      done_res <= 1'b1;
    end
  end

endmodule
`default_nettype wire
